>>> rtl/core/bat_pkg.sv
package bat_pkg;

  localparam int WORK_W     = 32;  // linear address / quotient width
  localparam int SPT_W      = 8;   // sectors-per-track divisor width
  localparam int HC_W       = 5;   // head-count divisor width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LBA_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LBA_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHS_BASE   = 3'd4;

  // reset values
  localparam logic             RST_LBA_MODE   = 1'b0;
  localparam logic [SPT_W-1:0] RST_SPT        = 8'd63;
  localparam logic [HC_W-1:0]  RST_HEAD_COUNT = 5'd16;
  localparam logic [7:0]       RST_LBA_BASE   = 8'd224;
  localparam logic [7:0]       RST_CHS_BASE   = 8'd160;

  localparam logic [3:0] LBA_TOP_MASK = 4'hF;

  typedef struct packed {
    logic [WORK_W-1:0] block_address;
    logic [7:0]        block_count;
    logic [7:0]        command_code;
  } in_word_t;

  typedef struct packed {
    logic [7:0] device_head;
    logic [7:0] sector_count_out;
    logic [7:0] sector_number;
    logic [7:0] cylinder_low;
    logic [7:0] cylinder_high;
    logic [7:0] command_out;
    logic       range_error;
  } out_word_t;

  // what rides along the head-division row: the request and the sector remainder
  typedef struct packed {
    in_word_t         req;
    logic [SPT_W-1:0] sec_rem;
  } mid_word_t;

endpackage

>>> rtl/core/bat_div_cell.sv
// One restoring-division step: brings in one dividend bit, produces one quotient bit.
module bat_div_cell #(
  parameter int DW = bat_pkg::SPT_W,
  parameter int PW = $bits(bat_pkg::in_word_t)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [DW-1:0]             div,
  input  logic                      i_valid,
  input  logic [DW-1:0]             i_rem,
  input  logic [bat_pkg::WORK_W-1:0] i_work,
  input  logic [PW-1:0]             i_pass,
  output logic                      valid_r,
  output logic [DW-1:0]             rem_r,
  output logic [bat_pkg::WORK_W-1:0] work_r,
  output logic [PW-1:0]             pass_r
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    trial   = {i_rem, i_work[bat_pkg::WORK_W-1]};
    diff    = trial - {1'b0, div};
    ge      = (trial >= {1'b0, div});
    // remainder stays below the divisor, so DW bits hold it
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      work_r <= {i_work[bat_pkg::WORK_W-2:0], ge};
      pass_r <= i_pass;
    end
  end

endmodule

>>> rtl/core/bat_div_chain.sv
// Row of division cells, one per dividend bit. Work leaves as the quotient.
module bat_div_chain #(
  parameter int DW = bat_pkg::SPT_W,
  parameter int PW = $bits(bat_pkg::in_word_t)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [DW-1:0]             div,
  input  logic                      i_valid,
  input  logic [bat_pkg::WORK_W-1:0] i_dividend,
  input  logic [PW-1:0]             i_pass,
  output logic                      o_valid,
  output logic [DW-1:0]             o_rem,
  output logic [bat_pkg::WORK_W-1:0] o_quo,
  output logic [PW-1:0]             o_pass
);

  localparam int N = bat_pkg::WORK_W;

  logic                       vld  [0:N];
  logic [DW-1:0]              rem  [0:N];
  logic [bat_pkg::WORK_W-1:0] work [0:N];
  logic [PW-1:0]              pass [0:N];

  assign vld[0]  = i_valid;
  assign rem[0]  = '0;
  assign work[0] = i_dividend;
  assign pass[0] = i_pass;

  for (genvar k = 0; k < N; k++) begin : g_cell
    bat_div_cell #(
      .DW(DW),
      .PW(PW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .div    (div),
      .i_valid(vld[k]),
      .i_rem  (rem[k]),
      .i_work (work[k]),
      .i_pass (pass[k]),
      .valid_r(vld[k+1]),
      .rem_r  (rem[k+1]),
      .work_r (work[k+1]),
      .pass_r (pass[k+1])
    );
  end

  assign o_valid = vld[N];
  assign o_rem   = rem[N];
  assign o_quo   = work[N];
  assign o_pass  = pass[N];

endmodule

>>> rtl/core/block_address_to_task_file.sv
// Block request to disk task-file translator. Each accepted input word (linear
// block address, block count, command byte) yields one output word holding the
// six task-file register values plus a range flag, in order. A new word can be
// accepted every cycle unless in_stall is high. The path is two rows of 32
// restoring-division cells (address / sectors_per_track, then quotient /
// head_count, one quotient bit per cell) and one output register. Linear mode
// still runs through the same rows so words stay in order; the mode is applied
// at the end of the row. A skid register behind the output register absorbs
// the word arriving while the output is stalled; in_stall is that skid's full
// flag, so the input only stalls once a word is parked behind a held output.
// Divisors of zero act as one. Configuration writes (cfg_wr_en, cfg_index,
// cfg_wdata) must only happen while no word is in flight; unknown indexes are
// dropped.
module block_address_to_task_file (
  input  logic                                clk,
  input  logic                                rst_n,
  // request side
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bat_pkg::in_word_t                   in_data,
  // task-file side
  output logic                                out_valid,
  input  logic                                out_stall,
  output bat_pkg::out_word_t                  out_data,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [bat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bat_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // ---------------------------------------------------------------- config
  logic                      lba_mode_r;
  logic [bat_pkg::SPT_W-1:0] spt_r;
  logic [bat_pkg::HC_W-1:0]  hc_r;
  logic [7:0]                lba_base_r;
  logic [7:0]                chs_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_mode_r <= bat_pkg::RST_LBA_MODE;
      spt_r      <= bat_pkg::RST_SPT;
      hc_r       <= bat_pkg::RST_HEAD_COUNT;
      lba_base_r <= bat_pkg::RST_LBA_BASE;
      chs_base_r <= bat_pkg::RST_CHS_BASE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bat_pkg::CFG_LBA_MODE:   lba_mode_r <= cfg_wdata[0];
        bat_pkg::CFG_SPT:        spt_r      <= cfg_wdata[bat_pkg::SPT_W-1:0];
        bat_pkg::CFG_HEAD_COUNT: hc_r       <= cfg_wdata[bat_pkg::HC_W-1:0];
        bat_pkg::CFG_LBA_BASE:   lba_base_r <= cfg_wdata[7:0];
        bat_pkg::CFG_CHS_BASE:   chs_base_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // zero divisor behaves as one
  logic [bat_pkg::SPT_W-1:0] spt_div;
  logic [bat_pkg::HC_W-1:0]  hc_div;
  assign spt_div = (spt_r == '0) ? bat_pkg::SPT_W'(1) : spt_r;
  assign hc_div  = (hc_r == '0)  ? bat_pkg::HC_W'(1)  : hc_r;

  // ---------------------------------------------------------------- pipe
  // both division rows advance unless the skid register holds a word
  logic skid_valid_r;
  logic en;
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  logic                              s1_valid;
  logic [bat_pkg::SPT_W-1:0]         s1_rem;
  logic [bat_pkg::WORK_W-1:0]        s1_quo;
  logic [$bits(bat_pkg::in_word_t)-1:0] s1_pass;
  bat_pkg::mid_word_t                s1_mid;

  bat_div_chain #(
    .DW(bat_pkg::SPT_W),
    .PW($bits(bat_pkg::in_word_t))
  ) u_sec_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .div       (spt_div),
    .i_valid   (in_valid),
    .i_dividend(in_data.block_address),
    .i_pass    (in_data),
    .o_valid   (s1_valid),
    .o_rem     (s1_rem),
    .o_quo     (s1_quo),
    .o_pass    (s1_pass)
  );

  assign s1_mid.req     = s1_pass;
  assign s1_mid.sec_rem = s1_rem;

  logic                                  s2_valid;
  logic [bat_pkg::HC_W-1:0]              s2_rem;
  logic [bat_pkg::WORK_W-1:0]            s2_quo;
  logic [$bits(bat_pkg::mid_word_t)-1:0] s2_pass;

  bat_div_chain #(
    .DW(bat_pkg::HC_W),
    .PW($bits(bat_pkg::mid_word_t))
  ) u_head_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .div       (hc_div),
    .i_valid   (s1_valid),
    .i_dividend(s1_quo),
    .i_pass    (s1_mid),
    .o_valid   (s2_valid),
    .o_rem     (s2_rem),
    .o_quo     (s2_quo),
    .o_pass    (s2_pass)
  );

  // ---------------------------------------------------------------- format
  bat_pkg::mid_word_t tail;
  bat_pkg::out_word_t res;
  logic [bat_pkg::WORK_W-1:0] addr;

  assign tail = s2_pass;
  assign addr = tail.req.block_address;

  always_comb begin
    res.sector_count_out = tail.req.block_count;
    res.command_out      = tail.req.command_code;
    if (lba_mode_r) begin
      res.sector_number = addr[7:0];
      res.cylinder_low  = addr[15:8];
      res.cylinder_high = addr[23:16];
      res.device_head   = {4'b0, addr[27:24] & bat_pkg::LBA_TOP_MASK} | lba_base_r;
      res.range_error   = |addr[31:28];   // beyond 28-bit addressing
    end else begin
      res.sector_number = tail.sec_rem + 8'd1;  // sectors count from one
      res.cylinder_low  = s2_quo[7:0];
      res.cylinder_high = s2_quo[15:8];
      res.device_head   = chs_base_r + {3'b0, s2_rem};  // wraps mod 256
      res.range_error   = |s2_quo[31:16];  // cylinder past 65535
    end
  end

  // ---------------------------------------------------------------- output
  logic               out_valid_r;
  bat_pkg::out_word_t out_data_r;
  bat_pkg::out_word_t skid_data_r;
  logic               out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= s2_valid;
      end
    end else if (s2_valid && en) begin
      // output held: park the arriving word
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (!out_free && en) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/bat_checker.sv
module bat_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bat_pkg::out_word_t out_data
);

  // held output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output word changed while stalled");

  // input back-pressure only appears behind a held output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

endmodule

bind block_address_to_task_file bat_checker u_bat_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
